[rtl/mpvs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mpvs_pkg
// Shared types, constants and the output shift-and-saturate helper for the skinning block.
// ----------------------------------------------------------------------------
package mpvs_pkg;

   localparam int unsigned WORD_W      = 32;
   localparam int unsigned ELEMS       = 12;
   localparam int unsigned BONE_W      = 10;
   localparam int unsigned ELEM_W      = 4;
   localparam int unsigned COUNT_W     = 11;
   localparam int unsigned QUEUE_DEPTH = 8;
   localparam int unsigned OCC_W       = $clog2(QUEUE_DEPTH + 1);
   localparam int unsigned SUM_W       = 66;

   typedef enum logic {
      ACT_WRITE  = 1'b0,
      ACT_VERTEX = 1'b1
   } action_type;

   typedef enum logic {
      CSR_BONE_COUNT     = 1'b0,
      CSR_NORMALS_ENABLE = 1'b1
   } csr_index_type;

   // classified vertex handed from front to back
   typedef struct packed {
      logic                   err;
      logic                   nen;
      logic                   last;
      logic [2:0][WORD_W-1:0] pos;
      logic [2:0][WORD_W-1:0] nrm;
   } vtx_type;

   // component order: x, y, z, nx, ny, nz
   typedef struct packed {
      logic [5:0][WORD_W-1:0] comp;
      logic                   status;
      logic                   last;
   } rsp_type;

   function automatic logic [WORD_W-1:0] shift_sat(input logic signed [SUM_W-1:0] s);
      logic signed [SUM_W-1:0] q;
      q = s >>> 16;
      if (q > 66'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end else if (q < -66'sd2147483648) begin
         return 32'h8000_0000;
      end else begin
         return q[WORD_W-1:0];
      end
   endfunction

endpackage
`default_nettype wire

[rtl/matrix_palette_vertex_skinning.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// matrix_palette_vertex_skinning
// Rigid matrix-palette skinning of Q16.16 vertices with palette write items.
//
//   channel  ports                      handshake
//   request  req_*                      push / full
//   response rsp_*                      pop / empty
//   control  csr_we, csr_index, csr_wdata   write on csr_we
//
// One item per cycle is accepted while full is low; a vertex result passes
// the palette read, multiply and row sum registers, is saturated and enters
// the result queue. Palette writes produce no result. full rises when
// queued plus in-flight vertices reach the queue depth. Reset sets control
// defaults, empties credits and queue; palette is undefined until written.
// ----------------------------------------------------------------------------
module matrix_palette_vertex_skinning #(
   parameter int unsigned PALETTE_DEPTH = 1024
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        push,
   output logic             full,
   input  wire logic        req_action,
   input  wire logic [9:0]  req_bone_index,
   input  wire logic [3:0]  req_matrix_element,
   input  wire logic [31:0] req_matrix_value,
   input  wire logic [31:0] req_pos_x,
   input  wire logic [31:0] req_pos_y,
   input  wire logic [31:0] req_pos_z,
   input  wire logic [31:0] req_nrm_x,
   input  wire logic [31:0] req_nrm_y,
   input  wire logic [31:0] req_nrm_z,
   input  wire logic        req_last_vertex,
   output logic             empty,
   input  wire logic        pop,
   output logic [31:0]      rsp_out_x,
   output logic [31:0]      rsp_out_y,
   output logic [31:0]      rsp_out_z,
   output logic [31:0]      rsp_out_nx,
   output logic [31:0]      rsp_out_ny,
   output logic [31:0]      rsp_out_nz,
   output logic             rsp_status,
   output logic             rsp_last_out,
   input  wire logic        csr_we,
   input  wire logic        csr_index,
   input  wire logic [10:0] csr_wdata
);
   import mpvs_pkg::*;

   logic [COUNT_W-1:0] bone_count_ff;
   logic               nen_ff;
   logic [OCC_W-1:0]   occ_ff, occ_in;
   logic               take, vtx_take, do_pop;
   logic               vtx_valid, rsp_valid;
   vtx_type            vtx;
   rsp_type            rsp_d, rsp_q;
   logic [ELEMS-1:0][WORD_W-1:0] mat;

   assign full     = (occ_ff == OCC_W'(QUEUE_DEPTH));
   assign take     = push && !full;
   assign vtx_take = take && (req_action == ACT_VERTEX);
   assign do_pop   = pop && !empty;
   assign occ_in   = occ_ff + OCC_W'(vtx_take) - OCC_W'(do_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         bone_count_ff <= 11'd1024;
         nen_ff        <= 1'b1;
         occ_ff        <= '0;
      end else begin
         occ_ff <= occ_in;
         if (csr_we) begin
            unique case (csr_index)
               CSR_BONE_COUNT:     bone_count_ff <= csr_wdata;
               CSR_NORMALS_ENABLE: nen_ff        <= csr_wdata[0];
               default: ;
            endcase
         end
      end
   end

   mpvs_front #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_front (
      .clock          (clock),
      .reset          (reset),
      .take           (take),
      .action         (req_action),
      .bone_index     (req_bone_index),
      .matrix_element (req_matrix_element),
      .matrix_value   (req_matrix_value),
      .pos            ({req_pos_z, req_pos_y, req_pos_x}),
      .nrm            ({req_nrm_z, req_nrm_y, req_nrm_x}),
      .last_vertex    (req_last_vertex),
      .bone_count     (bone_count_ff),
      .normals_enable (nen_ff),
      .vtx_valid      (vtx_valid),
      .vtx            (vtx),
      .mat            (mat)
   );

   mpvs_back u_back (
      .clock     (clock),
      .reset     (reset),
      .vtx_valid (vtx_valid),
      .vtx       (vtx),
      .mat       (mat),
      .rsp_valid (rsp_valid),
      .rsp       (rsp_d)
   );

   mpvs_fifo u_fifo (
      .clock (clock),
      .reset (reset),
      .push  (rsp_valid),
      .wdata (rsp_d),
      .pop   (pop),
      .empty (empty),
      .rdata (rsp_q)
   );

   assign rsp_out_x    = rsp_q.comp[0];
   assign rsp_out_y    = rsp_q.comp[1];
   assign rsp_out_z    = rsp_q.comp[2];
   assign rsp_out_nx   = rsp_q.comp[3];
   assign rsp_out_ny   = rsp_q.comp[4];
   assign rsp_out_nz   = rsp_q.comp[5];
   assign rsp_status   = rsp_q.status;
   assign rsp_last_out = rsp_q.last;

   // credit count never goes past the queue depth
   a_occ_bound: assert property (@(posedge clock) disable iff (reset)
      occ_ff <= OCC_W'(QUEUE_DEPTH))
      else $error("occupancy above queue depth");

   // a flagged result carries zero x and nz components
   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_status) |-> (rsp_out_x == '0 && rsp_out_nz == '0))
      else $error("flagged result not zeroed");

   // every accepted vertex reaches the queue after the palette read, product and sum registers
   a_latency: assert property (@(posedge clock) disable iff (reset)
      vtx_take |-> ##3 rsp_valid)
      else $error("vertex lost in datapath");

   // no credits held means an empty queue with nothing in flight
   a_credit: assert property (@(posedge clock) disable iff (reset)
      (occ_ff == '0) |-> (empty && !vtx_valid && !rsp_valid))
      else $error("credit count out of step");

endmodule
`default_nettype wire

[rtl/mpvs_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mpvs_front
// Accepts items, writes palette words, range-checks vertices and reads the
// bone matrix from twelve palette banks.
// ----------------------------------------------------------------------------
module mpvs_front #(
   parameter int unsigned PALETTE_DEPTH = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          take,
   input  wire logic                          action,
   input  wire logic [mpvs_pkg::BONE_W-1:0]   bone_index,
   input  wire logic [mpvs_pkg::ELEM_W-1:0]   matrix_element,
   input  wire logic [mpvs_pkg::WORD_W-1:0]   matrix_value,
   input  wire logic [2:0][mpvs_pkg::WORD_W-1:0] pos,
   input  wire logic [2:0][mpvs_pkg::WORD_W-1:0] nrm,
   input  wire logic                          last_vertex,
   input  wire logic [mpvs_pkg::COUNT_W-1:0]  bone_count,
   input  wire logic                          normals_enable,
   output logic                               vtx_valid,
   output mpvs_pkg::vtx_type                  vtx,
   output logic [mpvs_pkg::ELEMS-1:0][mpvs_pkg::WORD_W-1:0] mat
);
   import mpvs_pkg::*;

   localparam int unsigned AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;

   logic          bone_ok;
   logic          wr_en;
   logic          rd_en;
   logic [14:0]   bone_wide;
   logic [AW-1:0] addr;
   logic          vld_ff, vld_in;
   vtx_type       vtx_ff, vtx_in;

   assign bone_wide = {5'b0, bone_index};
   assign addr      = bone_wide[AW-1:0];
   assign bone_ok   = (32'(bone_index) < PALETTE_DEPTH);
   assign wr_en     = take && (action == ACT_WRITE) && bone_ok
                      && (matrix_element < ELEM_W'(ELEMS));
   assign rd_en     = take && (action == ACT_VERTEX);

   always_comb begin
      vld_in     = rd_en;
      vtx_in.err = !bone_ok || ({1'b0, bone_index} >= bone_count);
      vtx_in.nen = normals_enable;
      vtx_in.last = last_vertex;
      vtx_in.pos = pos;
      vtx_in.nrm = nrm;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      if (rd_en) begin
         vtx_ff <= vtx_in;
      end
   end

   // one bank per matrix word so all twelve words of a matrix are read together
   for (genvar e = 0; e < ELEMS; e++) begin : g_bank
      logic [WORD_W-1:0] mem [PALETTE_DEPTH];
      logic [WORD_W-1:0] q_ff;
      always_ff @(posedge clock) begin
         if (wr_en && (matrix_element == ELEM_W'(e))) begin
            mem[addr] <= matrix_value;
         end
         if (rd_en) begin
            q_ff <= mem[addr];
         end
      end
      assign mat[e] = q_ff;
   end

   assign vtx_valid = vld_ff;
   assign vtx       = vtx_ff;

endmodule
`default_nettype wire

[rtl/mpvs_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mpvs_back
// Transform datapath: registered products and row sums, then combinational shift and saturate.
// ----------------------------------------------------------------------------
module mpvs_back (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                vtx_valid,
   input  wire mpvs_pkg::vtx_type   vtx,
   input  wire logic [mpvs_pkg::ELEMS-1:0][mpvs_pkg::WORD_W-1:0] mat,
   output logic                     rsp_valid,
   output mpvs_pkg::rsp_type        rsp
);
   import mpvs_pkg::*;

   logic                    p_vld_ff, s_vld_ff;
   logic                    p_err_ff, p_nen_ff, p_last_ff;
   logic                    s_err_ff, s_nen_ff, s_last_ff;
   logic signed [63:0]      prod_ff [18];
   logic signed [63:0]      prod_in [18];
   logic [WORD_W-1:0]       t_ff [3];
   logic signed [SUM_W-1:0] sum_ff [6];
   logic signed [SUM_W-1:0] sum_in [6];

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r*3+c]     = $signed(mat[r*4+c]) * $signed(vtx.pos[c]);
            prod_in[9+r*3+c]   = $signed(mat[r*4+c]) * $signed(vtx.nrm[c]);
         end
      end
   end

   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = SUM_W'(prod_ff[r*3]) + SUM_W'(prod_ff[r*3+1])
                   + SUM_W'(prod_ff[r*3+2])
                   + SUM_W'($signed({t_ff[r], 16'h0000}));
         sum_in[3+r] = SUM_W'(prod_ff[9+r*3]) + SUM_W'(prod_ff[9+r*3+1])
                     + SUM_W'(prod_ff[9+r*3+2]);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p_vld_ff <= 1'b0;
         s_vld_ff <= 1'b0;
      end else begin
         p_vld_ff <= vtx_valid;
         s_vld_ff <= p_vld_ff;
      end
      for (int i = 0; i < 18; i++) begin
         prod_ff[i] <= prod_in[i];
      end
      for (int r = 0; r < 3; r++) begin
         t_ff[r] <= mat[r*4+3];
      end
      p_err_ff  <= vtx.err;
      p_nen_ff  <= vtx.nen;
      p_last_ff <= vtx.last;
      for (int i = 0; i < 6; i++) begin
         sum_ff[i] <= sum_in[i];
      end
      s_err_ff  <= p_err_ff;
      s_nen_ff  <= p_nen_ff;
      s_last_ff <= p_last_ff;
   end

   always_comb begin
      for (int i = 0; i < 6; i++) begin
         if (s_err_ff || ((i >= 3) && !s_nen_ff)) begin
            rsp.comp[i] = '0;
         end else begin
            rsp.comp[i] = shift_sat(sum_ff[i]);
         end
      end
      rsp.status = s_err_ff;
      rsp.last   = s_last_ff;
   end

   assign rsp_valid = s_vld_ff;

endmodule
`default_nettype wire

[rtl/mpvs_fifo.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// mpvs_fifo
// Result queue between the datapath and the consumer.
// ----------------------------------------------------------------------------
module mpvs_fifo (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              push,
   input  wire mpvs_pkg::rsp_type wdata,
   input  wire logic              pop,
   output logic                   empty,
   output mpvs_pkg::rsp_type      rdata
);
   import mpvs_pkg::*;

   localparam int unsigned PW = $clog2(QUEUE_DEPTH);

   rsp_type         store [QUEUE_DEPTH];
   logic [PW-1:0]   wr_ff, wr_in;
   logic [PW-1:0]   rd_ff, rd_in;
   logic [OCC_W-1:0] cnt_ff, cnt_in;
   logic            do_pop;

   assign empty  = (cnt_ff == '0);
   assign do_pop = pop && !empty;
   assign rdata  = store[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = do_pop ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + OCC_W'(push) - OCC_W'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) begin
         store[wr_ff] <= wdata;
      end
   end

endmodule
`default_nettype wire
